/* src/scan_curvature_occlusion_marker_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the curvature / occlusion marker
// Clocked, reset-gated property shorthands used by the port checker.
// ---------------------------------------------------------------------------
`ifndef SCAN_CURVATURE_OCCLUSION_MARKER_ASSERT_SVH
`define SCAN_CURVATURE_OCCLUSION_MARKER_ASSERT_SVH

// same-cycle implication
`define SCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scm assertion failed: same-cycle check");

// next-cycle implication
`define SCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scm assertion failed: next-cycle check");

`endif

/* src/scm_pkg.sv */
// ---------------------------------------------------------------------------
// scm_pkg
// Shared types and constants of the curvature / occlusion marker.
// ---------------------------------------------------------------------------
package scm_pkg;

    // field widths fixed by the stream format
    localparam int IN_RANGE_W = 18;
    localparam int IN_COL_W   = 12;
    localparam int CURV_W     = 43;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int IN_RANGE_LSB = 0;
    localparam int IN_COL_LSB   = IN_RANGE_LSB + IN_RANGE_W;

    // configuration port
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_OCC_W    = 16;
    localparam int CFG_PAR_W    = 8;
    localparam int CFG_COLGAP_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_OCC_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAR_INV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_GAP = 2'd2;

    localparam logic [CFG_OCC_W-1:0]    OCC_GAP_RST = 16'd300;
    localparam logic [CFG_PAR_W-1:0]    PAR_INV_RST = 8'd50;
    localparam logic [CFG_COLGAP_W-1:0] COL_GAP_RST = 12'd10;

    typedef struct packed {
        logic [CFG_OCC_W-1:0]    occ_gap;
        logic [CFG_PAR_W-1:0]    par_inv;
        logic [CFG_COLGAP_W-1:0] col_gap;
    } cfg_t;

    // one result request from the window to the curvature pipe
    typedef struct packed {
        logic is_edge;    // edge point: curvature forced to zero
        logic excl;       // excluded flag, edge already folded in
        logic last;       // final result of the cloud
        logic ctr_shift;  // center one slot deeper in the window
    } emit_t;

endpackage

/* src/scm_cfg.sv */
// ---------------------------------------------------------------------------
// scm_cfg
// Configuration register file, write only.
// ---------------------------------------------------------------------------
module scm_cfg
    import scm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.occ_gap <= OCC_GAP_RST;
            cfg_reg.par_inv <= PAR_INV_RST;
            cfg_reg.col_gap <= COL_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OCC_GAP: cfg_reg.occ_gap <= CFG_OCC_W'(cfg_data);
                REG_PAR_INV: cfg_reg.par_inv <= CFG_PAR_W'(cfg_data);
                REG_COL_GAP: cfg_reg.col_gap <= CFG_COLGAP_W'(cfg_data);
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/scm_window.sv */
// ---------------------------------------------------------------------------
// scm_window
// Point window, pair checks (occlusion, beam-parallel) and tail flush.
// ---------------------------------------------------------------------------
module scm_window
    import scm_pkg::*;
#(
    parameter int HALF_WINDOW = 5,
    parameter int RANGE_BITS  = 18,
    parameter int COLUMN_BITS = 12
)(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  cfg_t                                       cfg,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [IN_RANGE_W-1:0]                      in_range,
    input  logic [IN_COL_W-1:0]                        in_column,
    input  logic                                       in_last,
    input  logic                                       emit_ready,
    output logic                                       emit_valid,
    output emit_t                                      emit,
    output logic [2*HALF_WINDOW+1:0][RANGE_BITS-1:0]   rng_win
);

    localparam int RNG_DEPTH = 2 * HALF_WINDOW + 2;
    localparam int EXC_DEPTH = HALF_WINDOW + 2;
    localparam int SEEN_MAX  = 2 * HALF_WINDOW + 3;
    localparam int SEEN_W    = $clog2(SEEN_MAX + 1);
    localparam int PEND_W    = $clog2(HALF_WINDOW + 1);
    localparam int J_W       = $clog2(EXC_DEPTH);
    localparam int GAP_W     = (RANGE_BITS > CFG_OCC_W) ? RANGE_BITS : CFG_OCC_W;
    localparam int COLC_W    = (COLUMN_BITS > CFG_COLGAP_W) ? COLUMN_BITS : CFG_COLGAP_W;
    localparam int PAR_W     = RANGE_BITS + CFG_PAR_W;

    logic [RNG_DEPTH-1:0][RANGE_BITS-1:0] rng_reg;
    logic [COLUMN_BITS-1:0]               col_reg;
    logic [EXC_DEPTH-1:0]                 exc_reg, exc_next;
    logic [SEEN_W-1:0]                    seen_reg, seen_next;
    logic [PEND_W-1:0]                    pend_reg, pend_next;
    logic                                 flush_reg;
    logic [J_W-1:0]                       fj_reg;
    logic [SEEN_W-1:0]                    fidx_reg;

    logic [RANGE_BITS-1:0]  r0, r1, r2, d01, d21;
    logic [COLUMN_BITS-1:0] c_in, col_diff;
    logic                   accept, checks_on, same, back, fwd, par, flush_fire;
    logic                   fedge;

    // saturate range, mask column
    assign r0   = (|(in_range >> RANGE_BITS)) ? '1 : RANGE_BITS'(in_range);
    assign c_in = COLUMN_BITS'(in_column);
    assign r1   = rng_reg[0];
    assign r2   = rng_reg[1];

    assign d01      = (r0 >= r1) ? (r0 - r1) : (r1 - r0);
    assign d21      = (r2 >= r1) ? (r2 - r1) : (r1 - r2);
    assign col_diff = (c_in >= col_reg) ? (c_in - col_reg) : (col_reg - c_in);

    assign checks_on = (seen_reg >= SEEN_W'(HALF_WINDOW + 1));
    assign same      = (COLC_W'(col_diff) < COLC_W'(cfg.col_gap));
    assign back      = checks_on && same && (r1 > r0) &&
                       (GAP_W'(d01) > GAP_W'(cfg.occ_gap));
    assign fwd       = checks_on && same && !back && (r0 > r1) &&
                       (GAP_W'(d01) > GAP_W'(cfg.occ_gap));
    assign par       = checks_on &&
                       ((PAR_W'(d21) * PAR_W'(cfg.par_inv)) > PAR_W'(r1)) &&
                       ((PAR_W'(d01) * PAR_W'(cfg.par_inv)) > PAR_W'(r1));

    assign in_ready   = !flush_reg && emit_ready;
    assign accept     = in_valid && in_ready;
    assign flush_fire = flush_reg && emit_ready;

    always_comb
    begin
        exc_next = {exc_reg[EXC_DEPTH-2:0], (pend_reg != '0) || fwd};
        exc_next = exc_next | {{(EXC_DEPTH-1){back}}, 1'b0};
        exc_next = exc_next | (EXC_DEPTH'(par) << 1);

        if (fwd)
            pend_next = PEND_W'(HALF_WINDOW);
        else if (pend_reg != '0)
            pend_next = pend_reg - 1'b1;
        else
            pend_next = pend_reg;

        if (seen_reg < SEEN_W'(SEEN_MAX))
            seen_next = seen_reg + 1'b1;
        else
            seen_next = seen_reg;
    end

    // window payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rng_reg <= {rng_reg[RNG_DEPTH-2:0], r0};
            col_reg <= c_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exc_reg   <= '0;
            seen_reg  <= '0;
            pend_reg  <= '0;
            flush_reg <= 1'b0;
            fj_reg    <= '0;
            fidx_reg  <= '0;
        end
        else if (accept)
        begin
            exc_reg  <= exc_next;
            seen_reg <= seen_next;
            pend_reg <= pend_next;
            if (in_last)
            begin
                flush_reg <= 1'b1;
                fj_reg    <= checks_on ? J_W'(HALF_WINDOW + 1) : J_W'(seen_reg);
                fidx_reg  <= seen_reg;
            end
        end
        else if (flush_fire)
        begin
            if (fj_reg == '0)
            begin
                flush_reg <= 1'b0;
                seen_reg  <= '0;
                pend_reg  <= '0;
            end
            else
            begin
                fj_reg <= fj_reg - 1'b1;
            end
        end
    end

    assign fedge = (fj_reg < J_W'(HALF_WINDOW)) ||
                   (fidx_reg < (SEEN_W'(fj_reg) + SEEN_W'(HALF_WINDOW)));

    always_comb
    begin
        if (flush_reg)
        begin
            emit.is_edge   = fedge;
            emit.excl      = fedge || exc_reg[fj_reg];
            emit.last      = (fj_reg == '0);
            emit.ctr_shift = (fj_reg == J_W'(HALF_WINDOW + 1));
        end
        else
        begin
            // result of the point that holds the center slot as this transfer arrives
            emit.is_edge   = (seen_reg < SEEN_W'(2 * HALF_WINDOW + 1));
            emit.excl      = emit.is_edge || exc_reg[HALF_WINDOW] || back;
            emit.last      = 1'b0;
            emit.ctr_shift = 1'b0;
        end
    end

    assign emit_valid = flush_reg || (accept && !in_last && checks_on);
    assign rng_win    = rng_reg;

endmodule

/* src/scm_curv.sv */
// ---------------------------------------------------------------------------
// scm_curv
// Curvature pipe: neighbor sum stage, then abs diff, square and saturate.
// ---------------------------------------------------------------------------
module scm_curv
    import scm_pkg::*;
#(
    parameter int HALF_WINDOW = 5,
    parameter int RANGE_BITS  = 18
)(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       emit_valid,
    input  emit_t                                      emit,
    input  logic [2*HALF_WINDOW+1:0][RANGE_BITS-1:0]   rng_win,
    output logic                                       emit_ready,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [CURV_W-1:0]                          curvature,
    output logic                                       excluded,
    output logic                                       last
);

    localparam int N    = 2 * HALF_WINDOW;
    localparam int D_W  = RANGE_BITS + $clog2(N + 1);
    localparam int SQ_W = 2 * D_W;

    logic [N:0][RANGE_BITS-1:0] op;
    logic [D_W-1:0]             sum, ctr;

    logic           s1_valid_reg;
    logic [D_W-1:0] s1_sum_reg, s1_ctr_reg;
    logic           s1_edge_reg, s1_excl_reg, s1_last_reg;
    logic           s1_ready, s2_ready;

    logic [D_W-1:0]    diff;
    logic [SQ_W-1:0]   sq;
    logic [CURV_W-1:0] sat;

    logic              out_valid_reg;
    logic [CURV_W-1:0] curv_reg;
    logic              excl_reg, last_reg;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i <= N; i++)
        begin
            op[i] = emit.ctr_shift ? rng_win[i+1] : rng_win[i];
        end
        for (int i = 0; i <= N; i++)
        begin
            if (i != HALF_WINDOW)
                sum = sum + D_W'(op[i]);
        end
        ctr = D_W'(op[HALF_WINDOW]) * D_W'(N);
    end

    assign s2_ready   = !out_valid_reg || out_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign emit_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= emit_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && emit_valid)
        begin
            s1_sum_reg  <= sum;
            s1_ctr_reg  <= ctr;
            s1_edge_reg <= emit.is_edge;
            s1_excl_reg <= emit.excl;
            s1_last_reg <= emit.last;
        end
    end

    assign diff = (s1_sum_reg >= s1_ctr_reg) ? (s1_sum_reg - s1_ctr_reg)
                                             : (s1_ctr_reg - s1_sum_reg);
    assign sq   = SQ_W'(diff) * SQ_W'(diff);
    assign sat  = (|(sq >> CURV_W)) ? '1 : CURV_W'(sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            curv_reg <= s1_edge_reg ? '0 : sat;
            excl_reg <= s1_excl_reg;
            last_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign curvature = curv_reg;
    assign excluded  = excl_reg;
    assign last      = last_reg;

endmodule

/* src/scan_curvature_occlusion_marker.sv */
// Throughput: one point per cycle in and one result per cycle out while m_tready stays high
//   and no flush runs. A point's result is requested on the transfer of the point
//   HALF_WINDOW+1 later and passes both pipe registers. A cloud_end transfer holds s_tready low
//   while the tail drains via the single result path, one slot per cycle unless stalled.
// Reset (rst_n, async, active low) clears handshake state, counters, occlusion marks and the
//   configuration registers to their defaults; the range window itself is not reset.
// ---------------------------------------------------------------------------
// scan_curvature_occlusion_marker
// Lidar scan curvature with occlusion, beam-parallel and edge-point marking.
// ---------------------------------------------------------------------------
module scan_curvature_occlusion_marker
    import scm_pkg::*;
#(
    parameter int HALF_WINDOW = 5,
    parameter int RANGE_BITS  = 18,
    parameter int COLUMN_BITS = 12
)(
    input  logic                 clk,
    input  logic                 rst_n,
    // point stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [17:0] range_mm, [29:18] column, [31:30] zero
    input  logic                 s_tlast,   // cloud_end
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [42:0] curvature, [47:43] zero
    output logic                 m_tuser,   // [0] excluded
    output logic                 m_tlast,   // last_out
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t  cfg;
    emit_t emit;
    logic  emit_valid, emit_ready;
    logic [2*HALF_WINDOW+1:0][RANGE_BITS-1:0] rng_win;
    logic [CURV_W-1:0] curvature;

    scm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Window: every accepted point shifts in; pair checks on the newest pair set the
    // occlusion marks (backward over the last HALF_WINDOW+1 points, forward through a
    // pending count) and the beam-parallel mark. A normal transfer requests the result
    // of the center point in the same cycle; cloud_end starts a flush sequence that
    // walks the remaining slots oldest first and then empties the cloud state.
    scm_window #(
        .HALF_WINDOW (HALF_WINDOW),
        .RANGE_BITS  (RANGE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_range   (s_tdata[IN_RANGE_LSB +: IN_RANGE_W]),
        .in_column  (s_tdata[IN_COL_LSB +: IN_COL_W]),
        .in_last    (s_tlast),
        .emit_ready (emit_ready),
        .emit_valid (emit_valid),
        .emit       (emit),
        .rng_win    (rng_win)
    );

    // Curvature: neighbor sum and scaled center into a stage register, then
    // abs diff, square and saturate into the output register. The stage register
    // acts as skid for one request; input stalls once it also holds a result that cannot move on.
    scm_curv #(
        .HALF_WINDOW (HALF_WINDOW),
        .RANGE_BITS  (RANGE_BITS)
    ) u_curv (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_valid (emit_valid),
        .emit       (emit),
        .rng_win    (rng_win),
        .emit_ready (emit_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .curvature  (curvature),
        .excluded   (m_tuser),
        .last       (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(curvature);

endmodule

/* src/scm_checker.sv */
// ---------------------------------------------------------------------------
// scm_checker
// Port-level checks of the curvature / occlusion marker, bound to the top.
// ---------------------------------------------------------------------------
`include "scan_curvature_occlusion_marker_assert.svh"

module scm_checker
    import scm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    logic                 out_stall;
    logic [M_TDATA_W+1:0] out_word;

    assign out_stall = m_tvalid && !m_tready;
    assign out_word  = {m_tdata, m_tuser, m_tlast};

    // the last point of a cloud is always an edge point, and its result closes the flush
    `SCM_ASSERT_NOW(a_last_is_edge, clk, rst_n, m_tvalid && m_tlast, m_tuser && (m_tdata == '0))

    // a cloud_end transfer starts the flush, which holds s_tready low in the following cycle
    `SCM_ASSERT_NXT(a_flush_blocks_input, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready)

    // stalled result holds
    `SCM_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable(out_word))

endmodule

bind scan_curvature_occlusion_marker scm_checker u_scm_checker (.*);
